>>> hdl/refraction_container_tracker_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef REFRACTION_CONTAINER_TRACKER_DEFINES_SVH
`define REFRACTION_CONTAINER_TRACKER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define RCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/rct_pkg.sv
package rct_pkg;

    localparam int MAX_CONTAINERS = 8;
    localparam int ID_W           = 16;
    localparam int IDX_W          = 16;
    localparam logic [IDX_W-1:0] INDEX_ONE = IDX_W'(4096);

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        logic             any_match;
    } cmd_t;

    // Link from the lower neighbor.
    typedef struct packed {
        logic hit;
        logic valid;
    } link_t;

    // Entry handed down from the upper neighbor.
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
    } entry_t;

    // Cell status.
    typedef struct packed {
        entry_t           cur;
        logic             hit;
        logic             nvalid;
        logic [IDX_W-1:0] nidx;
    } cell_t;

endpackage

>>> hdl/rct_cell.sv
module rct_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  rct_pkg::cmd_t  cmd,
    input  rct_pkg::link_t low_i,
    input  rct_pkg::entry_t up_i,
    output rct_pkg::cell_t st_o
);

    logic                      valid_reg, valid_next;
    logic [rct_pkg::ID_W-1:0]  id_reg, id_next;
    logic [rct_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      self_match, hit, append;

    // Match chain: a match here or below removes this slot and shifts down
    assign self_match = valid_reg && (id_reg == cmd.id);
    assign hit        = low_i.hit | self_match;
    // First free slot appends when the object is not in the list
    assign append     = !valid_reg && low_i.valid && !cmd.any_match;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        if (hit) begin
            valid_next = up_i.valid;
            id_next    = up_i.id;
            idx_next   = up_i.idx;
        end else if (append) begin
            valid_next = 1'b1;
            id_next    = cmd.id;
            idx_next   = cmd.idx;
        end
    end

    // Slot valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.clear) begin
            valid_reg <= 1'b0;
        end else if (cmd.en) begin
            valid_reg <= valid_next;
        end
    end

    // Slot payload
    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            id_reg  <= id_next;
            idx_reg <= idx_next;
        end
    end

    assign st_o.cur.valid = valid_reg;
    assign st_o.cur.id    = id_reg;
    assign st_o.cur.idx   = idx_reg;
    assign st_o.hit       = hit;
    assign st_o.nvalid    = valid_next;
    assign st_o.nidx      = idx_next;

endmodule

>>> hdl/refraction_container_tracker.sv
// A result is registered and shows in the cycle after the request that causes it.
// Throughput: one request per cycle; the output register stalls input only
// while a result waits and m_ready is low.
// The container list is a row of cells with a one-bit match chain through it.
// Reset (aresetn low, synchronous) empties the list and clears hit and
// overflow flags; no clearing pass is needed.
`include "refraction_container_tracker_defines.svh"

module refraction_container_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_object_id,
    input  logic [15:0] s_refractive_index,
    input  logic        s_is_hit,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_index_from,
    output logic [15:0] m_index_to,
    output logic        m_hit_found,
    output logic        m_overflow
);

    localparam int N = rct_pkg::MAX_CONTAINERS;

    rct_pkg::cmd_t             cmd;
    rct_pkg::cell_t            cells [N];
    logic [N-1:0]              valid_vec;
    logic                      accept, any_match, push_drop;
    logic                      hit_done_reg, hit_done_next;
    logic                      ovf_reg, ovf_now;
    logic [rct_pkg::IDX_W-1:0] n1, n2;
    logic                      out_valid_reg;
    logic [15:0]               from_reg, to_reg;
    logic                      found_reg, ovf_out_reg;
    logic                      res_hit, res_miss;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Row of cells
    assign any_match     = cells[N-1].hit;
    assign cmd.en        = accept && !hit_done_reg;
    assign cmd.clear     = accept && s_last;
    assign cmd.id        = s_object_id;
    assign cmd.idx       = s_refractive_index;
    assign cmd.any_match = any_match;

    for (genvar i = 0; i < N; i++) begin : g_cell
        rct_pkg::link_t  low;
        rct_pkg::entry_t up;
        if (i == 0) begin : g_bot
            assign low.hit   = 1'b0;
            assign low.valid = 1'b1;
        end else begin : g_mid
            assign low.hit   = cells[i-1].hit;
            assign low.valid = cells[i-1].cur.valid;
        end
        if (i == N-1) begin : g_top
            assign up.valid = 1'b0;
            assign up.id    = '0;
            assign up.idx   = '0;
        end else begin : g_low
            assign up = cells[i+1].cur;
        end
        rct_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .low_i   (low),
            .up_i    (up),
            .st_o    (cells[i])
        );
        assign valid_vec[i] = cells[i].cur.valid;
    end

    // Newest entry before (n1) and after (n2) the toggle
    always_comb begin
        n1 = rct_pkg::INDEX_ONE;
        n2 = rct_pkg::INDEX_ONE;
        for (int i = 0; i < N; i++) begin
            if (cells[i].cur.valid && (i == N-1 || !cells[(i+1) % N].cur.valid)) begin
                n1 = cells[i].cur.idx;
            end
            if (cells[i].nvalid && (i == N-1 || !cells[(i+1) % N].nvalid)) begin
                n2 = cells[i].nidx;
            end
        end
    end

    assign push_drop = cells[N-1].cur.valid && !any_match;
    assign ovf_now   = ovf_reg || (cmd.en && push_drop);
    assign res_hit   = cmd.en && s_is_hit;
    assign res_miss  = cmd.en && !s_is_hit && s_last;

    assign hit_done_next = s_last ? 1'b0 : (hit_done_reg || res_hit);

    // Ray flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_done_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end else if (accept) begin
            hit_done_reg <= hit_done_next;
            ovf_reg      <= s_last ? 1'b0 : ovf_now;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_hit || res_miss) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_hit || res_miss) begin
            from_reg    <= res_hit ? n1 : rct_pkg::INDEX_ONE;
            to_reg      <= res_hit ? n2 : rct_pkg::INDEX_ONE;
            found_reg   <= res_hit;
            ovf_out_reg <= ovf_now;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_index_from = from_reg;
    assign m_index_to   = to_reg;
    assign m_hit_found  = found_reg;
    assign m_overflow   = ovf_out_reg;

    // Occupied cells stay packed at the bottom of the row
    `RCT_ASSERT_IMPL(a_packed, aclk, aresetn, 1'b1, ((valid_vec + N'(1)) & valid_vec) == '0)
    // A last request empties the list
    `RCT_ASSERT_NEXT(a_last_clears, aclk, aresetn, accept && s_last, valid_vec == '0)
    // A hit request yields a found result
    `RCT_ASSERT_NEXT(a_hit_result, aclk, aresetn, res_hit, m_valid && m_hit_found)
    // A miss result carries unit indices
    `RCT_ASSERT_IMPL(a_miss_unit, aclk, aresetn, m_valid && !m_hit_found,
        m_index_from == rct_pkg::INDEX_ONE && m_index_to == rct_pkg::INDEX_ONE)

endmodule
